FILE: src/psw_pkg.sv
package psw_pkg;

    typedef struct packed {
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
        logic        last_process;
    } psw_in_t;

    typedef struct packed {
        logic [4:0]  process_number;
        logic [15:0] burst_out;
        logic [19:0] waiting_time;
        logic [19:0] turnaround_time;
        logic [19:0] average_waiting;
        logic [19:0] average_turnaround;
        logic        items_dropped;
        logic        final_result;
    } psw_out_t;

    // Entry passed from the load side to the scheduling side
    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic        last;
    } psw_entry_t;

endpackage

FILE: src/psw_in_if.sv
interface psw_in_if;
    import psw_pkg::*;
    logic    valid;
    logic    ready;
    psw_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/psw_out_if.sv
interface psw_out_if;
    import psw_pkg::*;
    logic     valid;
    logic     ready;
    psw_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/psw_front.sv
module psw_front
    import psw_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    psw_in_if.sink     in_ch,
    output logic       q_valid,
    output psw_entry_t q_data,
    input  logic       q_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    psw_entry_t        fifo_reg [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    logic              push;

    assign in_ch.ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_data      = fifo_reg[rd_reg];

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg].burst <= in_ch.payload.burst_time;
            fifo_reg[wr_reg].prio  <= in_ch.payload.priority_req;
            fifo_reg[wr_reg].last  <= in_ch.payload.last_process;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end
endmodule

FILE: src/psw_back.sv
module psw_back
    import psw_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  psw_entry_t q_data,
    output logic       q_pop,
    psw_out_if.source  out_ch
);
    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int SW = 40;

    typedef enum logic [2:0] {S_LOAD, S_SCAN, S_SWAP, S_SUM, S_DIV, S_OUT} state_t;

    logic [15:0] burst_mem [MAX_PROCESSES];
    logic [7:0]  prio_mem  [MAX_PROCESSES];
    logic [4:0]  num_mem   [MAX_PROCESSES];

    state_t      state_reg;
    logic [CW-1:0] cnt_reg;
    logic        ovf_reg;
    logic [IW-1:0] i_reg, j_reg, best_reg;
    logic [7:0]  bestp_reg;
    logic [SW-1:0] tw_reg, tt_reg, wait_reg;
    logic [SW-1:0] rem_w_reg, rem_t_reg;
    logic [SW-1:0] qw_reg, qt_reg;
    logic [5:0]  bit_reg;
    logic        ov_reg;
    psw_out_t    out_reg;

    logic [SW-1:0] sh_w, sh_t, dv;
    logic [IW-1:0] cnt_m1;

    assign q_pop         = (state_reg == S_LOAD) && q_valid;
    assign out_ch.valid  = ov_reg;
    assign out_ch.payload = out_reg;
    assign cnt_m1        = IW'(cnt_reg - 1'b1);
    assign dv            = SW'(cnt_reg);
    assign sh_w          = {rem_w_reg[SW-2:0], tw_reg[bit_reg]};
    assign sh_t          = {rem_t_reg[SW-2:0], tt_reg[bit_reg]};

    // Scheduler sequencer: load, selection sort, sums, restoring divide, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // drain the output register outside the emit state
            if (ov_reg && out_ch.ready && state_reg != S_OUT)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (cnt_reg < CW'(MAX_PROCESSES))
                        begin
                            burst_mem[IW'(cnt_reg)] <= q_data.burst;
                            prio_mem[IW'(cnt_reg)]  <= q_data.prio;
                            num_mem[IW'(cnt_reg)]   <= 5'(cnt_reg + 1'b1);
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else
                            ovf_reg <= 1'b1;
                        if (q_data.last)
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            best_reg  <= '0;
                            bestp_reg <= 8'hFF;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // one compare per cycle, j walks i..n-1
                    if (j_reg == i_reg || prio_mem[j_reg] < bestp_reg)
                    begin
                        best_reg  <= j_reg;
                        bestp_reg <= prio_mem[j_reg];
                    end
                    if (j_reg == cnt_m1)
                        state_reg <= S_SWAP;
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_SWAP:
                begin
                    // nothing to move when the minimum is already in place
                    if (best_reg != i_reg)
                    begin
                        prio_mem[i_reg]     <= prio_mem[best_reg];
                        prio_mem[best_reg]  <= prio_mem[i_reg];
                        burst_mem[i_reg]    <= burst_mem[best_reg];
                        burst_mem[best_reg] <= burst_mem[i_reg];
                        num_mem[i_reg]      <= num_mem[best_reg];
                        num_mem[best_reg]   <= num_mem[i_reg];
                    end
                    if (i_reg == cnt_m1)
                    begin
                        i_reg    <= '0;
                        tw_reg   <= '0;
                        tt_reg   <= '0;
                        wait_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= i_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SUM:
                begin
                    tw_reg   <= tw_reg + wait_reg;
                    tt_reg   <= tt_reg + wait_reg + SW'(burst_mem[i_reg]);
                    wait_reg <= wait_reg + SW'(burst_mem[i_reg]);
                    if (i_reg == cnt_m1)
                    begin
                        bit_reg   <= 6'(SW-1);
                        rem_w_reg <= '0;
                        rem_t_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_DIV:
                begin
                    // one quotient bit per cycle for both averages
                    rem_w_reg <= (sh_w >= dv) ? sh_w - dv : sh_w;
                    rem_t_reg <= (sh_t >= dv) ? sh_t - dv : sh_t;
                    qw_reg[bit_reg] <= (sh_w >= dv);
                    qt_reg[bit_reg] <= (sh_t >= dv);
                    if (bit_reg == '0)
                    begin
                        i_reg    <= '0;
                        wait_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        ov_reg <= 1'b1;
                        out_reg.process_number     <= num_mem[i_reg];
                        out_reg.burst_out          <= burst_mem[i_reg];
                        out_reg.waiting_time       <= wait_reg[19:0];
                        out_reg.turnaround_time    <= 20'(wait_reg + SW'(burst_mem[i_reg]));
                        out_reg.average_waiting    <= qw_reg[19:0];
                        out_reg.average_turnaround <= qt_reg[19:0];
                        out_reg.items_dropped      <= ovf_reg;
                        out_reg.final_result       <= (i_reg == cnt_m1);
                        wait_reg <= wait_reg + SW'(burst_mem[i_reg]);
                        if (i_reg == cnt_m1)
                        begin
                            cnt_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule

FILE: src/priority_schedule_wait_times_unit.sv
// Non-preemptive priority scheduler. Processes arrive one request per cycle
// into a short input queue while it has room, and are loaded at one per
// cycle while the scheduler is in its load state; the request with
// last_process set starts a selection sort (one priority compare per cycle),
// a summing pass, a bit-serial division for the two averages, then one
// result per cycle in priority order while the output is accepted.
// Requests beyond MAX_PROCESSES are discarded and flagged on every result of
// that batch.
module priority_schedule_wait_times_unit
    import psw_pkg::*;
#(
    parameter int MAX_PROCESSES = 16
)
(
    input logic       clk,
    input logic       rst_n,
    psw_in_if.sink    in_ch,
    psw_out_if.source out_ch
);
    logic       q_valid;
    logic       q_pop;
    psw_entry_t q_data;

    psw_front #(.DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    psw_back #(.MAX_PROCESSES(MAX_PROCESSES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .out_ch(out_ch)
    );
endmodule

FILE: tb/tb_priority_schedule_wait_times_unit.sv
module tb_priority_schedule_wait_times_unit;
    import psw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 16;

    logic clk;
    logic rst_n;
    psw_in_if  in_ch ();
    psw_out_if out_ch ();

    priority_schedule_wait_times_unit #(.MAX_PROCESSES(CAPACITY)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Scheduler shadow state
    logic [15:0] sh_burst [CAPACITY];
    logic [7:0]  sh_prio  [CAPACITY];
    logic [4:0]  sh_num   [CAPACITY];
    int          sh_count;
    bit          sh_dropped;

    psw_out_t schedule_q[$];
    int       errors;
    int       requests_sent;
    int       results_seen;
    int       batches_done;
    bit       quiet_phase;
    bit       sink_quiet;

    // Directed stimulus; expected result typed in only for a single-process batch
    typedef struct {
        logic [15:0] burst;
        logic [7:0]  prio;
        bit          last;
        bit          has_exp;
        psw_out_t    exp;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // Store one process; on the last one, sort and push the expected schedule
    task automatic schedule_process(input logic [15:0] burst, input logic [7:0] prio,
                                    input bit last);
        int          best;
        logic [15:0] tb16;
        logic [7:0]  tp;
        logic [4:0]  tn;
        longint      acc;
        longint      tot_w;
        longint      tot_t;
        longint      avg_w;
        longint      avg_t;
        psw_out_t    r;
        if (sh_count < CAPACITY)
        begin
            sh_burst[sh_count] = burst;
            sh_prio[sh_count]  = prio;
            sh_num[sh_count]   = 5'(sh_count + 1);
            sh_count++;
        end
        else
            sh_dropped = 1;
        if (!last)
            return;
        // selection sort, strict less-than with swap (not stable)
        for (int i = 0; i < sh_count; i++)
        begin
            best = i;
            for (int j = i + 1; j < sh_count; j++)
                if (sh_prio[j] < sh_prio[best])
                    best = j;
            tp = sh_prio[i];  sh_prio[i]  = sh_prio[best];  sh_prio[best]  = tp;
            tb16 = sh_burst[i]; sh_burst[i] = sh_burst[best]; sh_burst[best] = tb16;
            tn = sh_num[i];   sh_num[i]   = sh_num[best];   sh_num[best]   = tn;
        end
        acc = 0; tot_w = 0; tot_t = 0;
        for (int i = 0; i < sh_count; i++)
        begin
            tot_w += acc;
            tot_t += acc + sh_burst[i];
            acc   += sh_burst[i];
        end
        avg_w = tot_w / sh_count;
        avg_t = tot_t / sh_count;
        acc = 0;
        for (int i = 0; i < sh_count; i++)
        begin
            r.process_number     = sh_num[i];
            r.burst_out          = sh_burst[i];
            r.waiting_time       = 20'(acc);
            r.turnaround_time    = 20'(acc + sh_burst[i]);
            r.average_waiting    = 20'(avg_w);
            r.average_turnaround = 20'(avg_t);
            r.items_dropped      = sh_dropped;
            r.final_result       = (i + 1 == sh_count);
            schedule_q.push_back(r);
            acc += sh_burst[i];
        end
        sh_count   = 0;
        sh_dropped = 0;
    endtask

    // Drive one request and wait for its acceptance
    task automatic send_process(input logic [15:0] burst, input logic [7:0] prio,
                                input bit last);
        while (!quiet_phase && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid                <= 1'b1;
        in_ch.payload.burst_time   <= burst;
        in_ch.payload.priority_req <= prio;
        in_ch.payload.last_process <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        schedule_process(burst, prio, last);
        requests_sent++;
    endtask

    task automatic add_row(input logic [15:0] b, input logic [7:0] p, input bit l);
        dir_row_t row;
        row.burst = b; row.prio = p; row.last = l; row.has_exp = 0; row.exp = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_single(input logic [15:0] b, input logic [7:0] p);
        dir_row_t row;
        row.burst = b; row.prio = p; row.last = 1; row.has_exp = 1;
        row.exp = '{process_number: 5'd1, burst_out: b, waiting_time: 20'd0,
                    turnaround_time: 20'(b), average_waiting: 20'd0,
                    average_turnaround: 20'(b), items_dropped: 1'b0,
                    final_result: 1'b1};
        dir_rows.push_back(row);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sink side: random stall, compare each result against the schedule
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (schedule_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result exp=none act=%p", $time, out_ch.payload);
                end
                else
                begin
                    if (out_ch.payload !== schedule_q[0])
                    begin
                        errors++;
                        $display("%0t: result mismatch exp=%p act=%p",
                                 $time, schedule_q[0], out_ch.payload);
                    end
                    if (schedule_q[0].final_result)
                        batches_done++;
                    void'(schedule_q.pop_front());
                end
            end
            out_ch.ready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    // Stimulus
    initial
    begin
        int n;
        errors = 0; requests_sent = 0; results_seen = 0; batches_done = 0;
        sh_count = 0; sh_dropped = 0; quiet_phase = 0; sink_quiet = 0;
        rst_n = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-process batches at the field extremes and an alternating bit pattern
        add_single(16'h0000, 8'h00);
        add_single(16'hFFFF, 8'hFF);
        add_single(16'h5555, 8'hAA);
        // ties in priority, and descending priorities
        add_row(16'd10, 8'd5, 0); add_row(16'd20, 8'd5, 0); add_row(16'd30, 8'd5, 1);
        add_row(16'hFFFF, 8'd3, 0); add_row(16'd1, 8'd2, 0);
        add_row(16'hAAAA, 8'd1, 0); add_row(16'd7, 8'd0, 1);
        foreach (dir_rows[i])
        begin
            send_process(dir_rows[i].burst, dir_rows[i].prio, dir_rows[i].last);
            if (dir_rows[i].has_exp && schedule_q[$] !== dir_rows[i].exp)
            begin
                errors++;
                $display("%0t: hand-typed row %0d exp=%p act=%p",
                         $time, i, dir_rows[i].exp, schedule_q[$]);
            end
        end
        // full store with overflow, last request arriving while full
        for (int i = 0; i < 19; i++)
            send_process(16'hFFFF, 8'($urandom_range(3)), i == 18);

        // random batches; a stretch without idling in the middle
        while (requests_sent < 530)
        begin
            quiet_phase = (requests_sent > 200 && requests_sent < 300);
            sink_quiet  = quiet_phase;
            case ($urandom_range(9))
                0:       n = CAPACITY + $urandom_range(1, 4);
                1:       n = CAPACITY;
                default: n = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < n; i++)
                send_process(16'($urandom), ($urandom_range(2) == 0) ? 8'($urandom_range(3))
                             : 8'($urandom), i == n - 1);
        end
        quiet_phase = 0;
        sink_quiet  = 0;
        in_ch.valid <= 1'b0;

        while (schedule_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d process requests in %0d batches; checked %0d schedule results.",
                 requests_sent, batches_done, results_seen);
        if (errors == 0)
            $display("priority_schedule_wait_times_unit: match");
        else
            $display("priority_schedule_wait_times_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("Timed out with %0d results outstanding.", schedule_q.size());
        $display("priority_schedule_wait_times_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
src/psw_pkg.sv
src/psw_in_if.sv
src/psw_out_if.sv
src/psw_front.sv
src/psw_back.sv
src/priority_schedule_wait_times_unit.sv
tb/tb_priority_schedule_wait_times_unit.sv
